// ===== design/bhpq_pkg.sv =====
// Shared types and constants of the binary heap priority queue.
// Used by bhpq_ctrl, bhpq_datapath and binary_heap_priority_queue; no dependencies.
`default_nettype none

package bhpq_pkg;

  // Operation codes carried on the request tuser.
  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_BUILD   = 2'd1,
    OP_EXTRACT = 2'd2,
    OP_PEEK    = 2'd3
  } op_t;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // Register index of order_mode, taken from bit 2 of the byte address.
  localparam logic CFG_ORDER_MODE_IDX = 1'b0;

  // Key width.
  localparam int KEY_W = 32;

  // Controller states, one-hot.
  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_BLD_INIT = 9'b000000010,
    S_BLD_RD   = 9'b000000100,
    S_BLD_SET  = 9'b000001000,
    S_ROOT_RD  = 9'b000010000,
    S_ROOT_SET = 9'b000100000,
    S_SIFT_RD  = 9'b001000000,
    S_SIFT_CMP = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // capture a new request, do an insert
    logic rd_root;    // read the root and the last slot
    logic root_set;   // take the root, and for extract move the last key up
    logic bld_init;   // point at the last inner node
    logic rd_node;    // read the current build node
    logic node_set;   // start a sift at the build node
    logic rd_kids;    // read both children of the hole
    logic sift_step;  // move one level down or park the sifting key
    logic bld_dec;    // step to the previous build node
    logic finish;     // load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  new_op;      // opcode of the offered request
    logic new_err;     // offered request fails (full or empty)
    op_t  op;          // opcode of the request at work
    logic count_small; // fewer than two keys stored
    logic cnt_one;     // exactly one key stored
    logic sift_stop;   // no child outranks the sifting key
    logic idx_zero;    // build node is the root
    logic out_busy;    // result register holds a result not yet taken
  } dp_status_t;

  // True when key a has strictly lower priority than key b.
  function automatic logic key_below(input logic mode,
                                     input logic signed [KEY_W-1:0] a,
                                     input logic signed [KEY_W-1:0] b);
    key_below = mode ? (a < b) : (a > b);
  endfunction

endpackage

`default_nettype wire

// ===== design/bhpq_ctrl.sv =====
// Controller state machine of the binary heap priority queue.
// Depends on bhpq_pkg; drives bhpq_datapath through dp_cmd_t.
`default_nettype none

module bhpq_ctrl
  import bhpq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire dp_status_t st,
  output dp_cmd_t         cmd
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          case (st.new_op)
            OP_INSERT: state_nxt = S_DONE;
            OP_BUILD:  state_nxt = S_BLD_INIT;
            default:   state_nxt = st.new_err ? S_DONE : S_ROOT_RD;
          endcase
        end
      end
      S_BLD_INIT: begin
        if (st.count_small) begin
          state_nxt = S_DONE;
        end else begin
          cmd.bld_init = 1'b1;
          state_nxt    = S_BLD_RD;
        end
      end
      S_BLD_RD: begin
        cmd.rd_node = 1'b1;
        state_nxt   = S_BLD_SET;
      end
      S_BLD_SET: begin
        cmd.node_set = 1'b1;
        state_nxt    = S_SIFT_RD;
      end
      S_ROOT_RD: begin
        cmd.rd_root = 1'b1;
        state_nxt   = S_ROOT_SET;
      end
      S_ROOT_SET: begin
        cmd.root_set = 1'b1;
        // A peek, or the last key out, leaves nothing to sift.
        if (st.op == OP_PEEK || st.cnt_one) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SIFT_RD;
        end
      end
      S_SIFT_RD: begin
        cmd.rd_kids = 1'b1;
        state_nxt   = S_SIFT_CMP;
      end
      S_SIFT_CMP: begin
        cmd.sift_step = 1'b1;
        if (!st.sift_stop) begin
          state_nxt = S_SIFT_RD;
        end else if (st.op == OP_BUILD && !st.idx_zero) begin
          cmd.bld_dec = 1'b1;
          state_nxt   = S_BLD_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/bhpq_datapath.sv =====
// Datapath of the binary heap priority queue: key memory, count, sift unit
// and result register. Depends on bhpq_pkg; commanded by bhpq_ctrl.
`default_nettype none

module bhpq_datapath
  import bhpq_pkg::*;
#(
  parameter int HEAP_DEPTH = 1024,
  parameter int CNT_W      = $clog2(HEAP_DEPTH + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    order_mode,
  input  wire dp_cmd_t                 cmd,
  output dp_status_t                   st,
  input  wire logic [1:0]              in_opcode,
  input  wire logic signed [KEY_W-1:0] in_key,
  input  wire logic                    out_tready,
  output logic                         out_valid,
  output logic signed [KEY_W-1:0]      out_key,
  output logic [CNT_W-1:0]             out_count,
  output logic [1:0]                   out_status
);

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = AW + 2;

  // Key memory: one write port, two registered read ports.
  logic signed [KEY_W-1:0] mem [HEAP_DEPTH];
  logic signed [KEY_W-1:0] rd_a_r, rd_b_r;
  logic [AW-1:0]           addr_a, addr_b, wr_addr;
  logic signed [KEY_W-1:0] wr_data;
  logic                    wr_en;

  logic [CNT_W-1:0]        count_r, count_nxt;
  op_t                     op_r;
  logic [1:0]              res_status_r;
  logic signed [KEY_W-1:0] res_key_r;
  logic signed [KEY_W-1:0] cur_r;
  logic [AW-1:0]           pos_r;
  logic [AW-1:0]           idx_r;
  logic                    out_valid_r;
  logic signed [KEY_W-1:0] out_key_r;
  logic [CNT_W-1:0]        out_count_r;
  logic [1:0]              out_status_r;

  logic       full, empty;
  op_t        new_op;
  logic [1:0] new_status;
  logic [CW-1:0] kid_l, kid_r, count_ext;
  logic       has_l, has_r, l_out, r_out, go_left, stop;
  logic signed [KEY_W-1:0] kid_key;
  logic [AW-1:0] kid_pos;

  assign full   = (count_r == CNT_W'(HEAP_DEPTH));
  assign empty  = (count_r == '0);
  assign new_op = op_t'(in_opcode);

  // Status of an offered request, judged on the count before it runs.
  always_comb begin
    new_status = STAT_OK;
    case (new_op)
      OP_INSERT:  new_status = full ? STAT_FULL : STAT_OK;
      OP_EXTRACT: new_status = empty ? STAT_EMPTY : STAT_OK;
      OP_PEEK:    new_status = empty ? STAT_EMPTY : STAT_OK;
      default:    new_status = STAT_OK;
    endcase
  end

  // Children of the hole and the sift decision.
  assign kid_l     = CW'({pos_r, 1'b1});
  assign kid_r     = kid_l + CW'(1);
  assign count_ext = CW'(count_r);
  assign has_l     = (kid_l < count_ext);
  assign has_r     = (kid_r < count_ext);
  assign l_out     = has_l && key_below(order_mode, cur_r, rd_a_r);
  assign r_out     = has_r && key_below(order_mode, cur_r, rd_b_r);
  assign stop      = !l_out && !r_out;
  // A tie between the children goes right.
  assign go_left   = l_out && (!r_out || key_below(order_mode, rd_b_r, rd_a_r));
  assign kid_key   = go_left ? rd_a_r : rd_b_r;
  assign kid_pos   = go_left ? kid_l[AW-1:0] : kid_r[AW-1:0];

  // Memory addresses and write selection.
  always_comb begin
    addr_a  = '0;
    addr_b  = '0;
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = cur_r;
    if (cmd.rd_kids) begin
      addr_a = kid_l[AW-1:0];
      addr_b = kid_r[AW-1:0];
    end else if (cmd.rd_root) begin
      addr_b = AW'(count_r - CNT_W'(1));
    end else if (cmd.rd_node) begin
      addr_a = idx_r;
    end
    if (cmd.accept && new_op == OP_INSERT && !full) begin
      wr_en   = 1'b1;
      wr_addr = AW'(count_r);
      wr_data = in_key;
    end else if (cmd.sift_step) begin
      wr_en   = 1'b1;
      wr_addr = pos_r;
      wr_data = stop ? cur_r : kid_key;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[addr_a];
    rd_b_r <= mem[addr_b];
  end

  // Element count.
  always_comb begin
    count_nxt = count_r;
    if (cmd.accept && new_op == OP_INSERT && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.root_set && op_r == OP_EXTRACT) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Request, sift and build registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r         <= new_op;
      res_status_r <= new_status;
      res_key_r    <= '0;
    end
    if (cmd.root_set) begin
      res_key_r <= rd_a_r;
      cur_r     <= rd_b_r;
      pos_r     <= '0;
    end
    if (cmd.bld_init) begin
      idx_r <= AW'(count_r >> 1) - AW'(1);
    end
    if (cmd.bld_dec) begin
      idx_r <= idx_r - AW'(1);
    end
    if (cmd.node_set) begin
      cur_r <= rd_a_r;
      pos_r <= idx_r;
    end
    if (cmd.sift_step && !stop) begin
      pos_r <= kid_pos;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_key_r    <= res_key_r;
      out_count_r  <= count_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_key    = out_key_r;
  assign out_count  = out_count_r;
  assign out_status = out_status_r;

  // Status toward the controller.
  always_comb begin
    st             = '0;
    st.new_op      = new_op;
    st.new_err     = (new_status != STAT_OK);
    st.op          = op_r;
    st.count_small = (count_r < CNT_W'(2));
    st.cnt_one     = (count_r == CNT_W'(1));
    st.sift_stop   = stop;
    st.idx_zero    = (idx_r == '0);
    st.out_busy    = out_valid_r && !out_tready;
  end

endmodule

`default_nettype wire

// ===== design/binary_heap_priority_queue.sv =====
// Binary heap priority queue with heapify: config register, controller and datapath.
// Depends on bhpq_pkg, bhpq_ctrl and bhpq_datapath.
//
// Usage:
//   Requests arrive on the in_ stream: in_tuser holds the opcode (insert, build,
//   extract, peek), in_tdata the key for an insert. Every request gives exactly one
//   result on the out_ stream: key (root on a good extract or peek, else zero),
//   key count after the request, status. order_mode (APB register 0, byte address 0)
//   picks min-first (0) or max-first (1); write it only while the queue is idle.
// Operation:
//   One request is worked at a time: in_tready is high only while idle, and the
//   result is loaded as the queue returns to idle. Insert and failed requests go
//   straight to the result; peek reads the root, extract also moves the last key
//   up and sifts it down level by level, to the level where it stops. Build sifts
//   each inner node in turn, from the last one to the root. Each sift level reads
//   both children together; the decision and hole write follow in the next cycle.
// Reset and stall:
//   Reset empties the queue and sets min-first order; memory contents are not
//   cleared and need no clearing pass. A result waits in the output register while
//   the next request is accepted; a request that finishes while out_tready is
//   low waits until the register is free.
`default_nettype none

module binary_heap_priority_queue
  import bhpq_pkg::*;
#(
  parameter int HEAP_DEPTH = 1024
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // Request stream.
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [31:0]             in_tdata,  // [31:0] key_in
  input  wire logic [1:0]              in_tuser,  // [1:0] opcode
  // Result stream.
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  // [31:0] key_out, then count_out, then status, zero filled to whole bytes
  output logic [((34 + $clog2(HEAP_DEPTH + 1) + 7) / 8) * 8 - 1:0] out_tdata,
  // Configuration port.
  input  wire logic                    cfg_psel,
  input  wire logic                    cfg_penable,
  input  wire logic                    cfg_pwrite,
  input  wire logic [2:0]              cfg_paddr,
  input  wire logic [31:0]             cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int OUT_W = ((34 + CNT_W + 7) / 8) * 8;

  logic                    order_mode_r;
  dp_cmd_t                 cmd;
  dp_status_t              st;
  logic signed [KEY_W-1:0] out_key;
  logic [CNT_W-1:0]        out_count;
  logic [1:0]              out_status;

  // Configuration register.
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_mode_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[2] == CFG_ORDER_MODE_IDX) begin
      order_mode_r <= cfg_pwdata[0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == CFG_ORDER_MODE_IDX) ? {31'b0, order_mode_r} : 32'b0;

  // Controller.
  bhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // Datapath.
  bhpq_datapath #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .CNT_W      (CNT_W)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .order_mode (order_mode_r),
    .cmd        (cmd),
    .st         (st),
    .in_opcode  (in_tuser),
    .in_key     (in_tdata),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_key    (out_key),
    .out_count  (out_count),
    .out_status (out_status)
  );

  // Result packing, lowest field first.
  assign out_tdata = OUT_W'({out_status, out_count, out_key});

endmodule

`default_nettype wire
